/* rtl/b64d_pkg.sv */
`timescale 1ns / 1ps

package b64d_pkg;

  // ASCII codes that both the classifier and the decode stage care about.
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // What the front end makes of one accepted beat.
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FAIL,
    KIND_PAD,
    KIND_FINISH
  } item_kind_t;

  // Position inside the current quartet of digits.
  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2,
    PH_3
  } phase_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [5:0]  digit;
  } item_t;

  // One queue slot as it travels between the front end, the queue and the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_entry_t;

endpackage

/* rtl/b64d_ifs.sv */
`timescale 1ns / 1ps

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       finish;

  modport source (output valid, output in_byte, output finish, input ready);
  modport sink (input valid, input in_byte, input finish, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        is_final;
  logic [15:0] error_total;

  modport source (output valid, output data_byte, output is_final, output error_total,
                  input ready);
  modport sink (input valid, input data_byte, input is_final, input error_total,
                output ready);
endinterface

interface b64d_cfg_if;
  logic valid;
  logic ready;
  logic text_mode;

  modport source (output valid, output text_mode, input ready);
  modport sink (input valid, input text_mode, output ready);
endinterface

/* rtl/b64d_front.sv */
`timescale 1ns / 1ps

module b64d_front (
  b64d_in_if.sink            din,
  output b64d_pkg::q_entry_t push,
  input  logic               push_ready
);
  import b64d_pkg::*;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] CODE_PLUS  = 6'd62;
  localparam logic [5:0] CODE_SLASH = 6'd63;

  logic skip;

  // Whitespace is dropped here; everything else becomes one queue entry.
  always_comb begin
    skip            = 1'b0;
    push.item.kind  = KIND_FAIL;
    push.item.digit = '0;
    if (din.finish) begin
      push.item.kind = KIND_FINISH;
    end else begin
      case (din.in_byte) inside
        BYTE_TAB, BYTE_LF, BYTE_CR, BYTE_SPACE: begin
          skip = 1'b1;
        end
        CHAR_PAD: begin
          push.item.kind = KIND_PAD;
        end
        [8'h41:8'h5A]: begin
          push.item.kind  = KIND_DATA;
          push.item.digit = 6'(din.in_byte - CHAR_UPPER);
        end
        [8'h61:8'h7A]: begin
          push.item.kind  = KIND_DATA;
          push.item.digit = 6'(din.in_byte - CHAR_LOWER + LOWER_BASE);
        end
        [8'h30:8'h39]: begin
          push.item.kind  = KIND_DATA;
          push.item.digit = 6'(din.in_byte - CHAR_DIGIT + DIGIT_BASE);
        end
        CHAR_PLUS: begin
          push.item.kind  = KIND_DATA;
          push.item.digit = CODE_PLUS;
        end
        CHAR_SLASH: begin
          push.item.kind  = KIND_DATA;
          push.item.digit = CODE_SLASH;
        end
        default: begin
          push.item.kind = KIND_FAIL;
        end
      endcase
    end
  end

  assign din.ready  = push_ready;
  assign push.valid = din.valid && !skip;

endmodule

/* rtl/b64d_queue.sv */
`timescale 1ns / 1ps

module b64d_queue (
  input  logic               clk,
  input  logic               rst,
  input  b64d_pkg::q_entry_t push,
  output logic               push_ready,
  output b64d_pkg::q_entry_t pop,
  input  logic               pop_ready
);
  import b64d_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.item   = slots[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(DEPTH))
    else $error("queue occupancy exceeds its depth");

endmodule

/* rtl/b64d_back.sv */
`timescale 1ns / 1ps

module b64d_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  b64d_pkg::q_entry_t head,
  output logic               pop_ready,
  b64d_cfg_if.sink           cfg,
  b64d_out_if.source         dout
);
  import b64d_pkg::*;

  localparam int CW   = COUNT_WIDTH;
  localparam int EXTW = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0]   CNT_MAX = {CW{1'b1}};
  localparam logic [CW:0]     ONE_W   = (CW + 1)'(1);
  localparam logic [CW:0]     TWO_W   = (CW + 1)'(2);
  localparam logic [EXTW-1:0] REPORT_MAX = EXTW'(16'hFFFF);

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW:0] b);
    logic [CW+1:0] sum;
    sum = {2'b00, a} + {1'b0, b};
    return (sum > {2'b00, CNT_MAX}) ? CNT_MAX : sum[CW-1:0];
  endfunction

  logic           text_mode;
  phase_t         phase, phase_next;
  logic [7:0]     partial_bits, partial_next;
  logic [CW-1:0]  pending_pads, pads_next;
  logic           last_was_cr, cr_next;
  logic [CW-1:0]  error_count, error_next;
  logic [CW-1:0]  err_sum;
  logic [CW:0]    pads_w;
  logic [CW:0]    fin_add;
  logic [EXTW-1:0] err_ext;
  logic           advance;
  logic           emit;
  logic           fin;
  logic [7:0]     dec_byte;
  logic [15:0]    total;

  assign pop_ready = !dout.valid || dout.ready;
  assign advance   = head.valid && pop_ready;
  assign cfg.ready = 1'b1;
  assign pads_w    = {1'b0, pending_pads};

  // Pad check at end of message: the expected pad count depends on the phase.
  always_comb begin
    case (phase)
      PH_0:    fin_add = pads_w;
      PH_1:    fin_add = pads_w + ONE_W;
      PH_2:    fin_add = (pads_w >= TWO_W) ? pads_w - TWO_W : TWO_W - pads_w;
      PH_3:    fin_add = (pads_w >= ONE_W) ? pads_w - ONE_W : ONE_W - pads_w;
      default: fin_add = pads_w;
    endcase
  end

  always_comb begin
    phase_next   = phase;
    partial_next = partial_bits;
    pads_next    = pending_pads;
    cr_next      = last_was_cr;
    error_next   = error_count;
    err_sum      = error_count;
    emit         = 1'b0;
    fin          = 1'b0;
    dec_byte     = '0;
    if (advance) begin
      case (head.item.kind)
        KIND_FINISH: begin
          err_sum      = sat_add(error_count, fin_add);
          emit         = 1'b1;
          fin          = 1'b1;
          phase_next   = PH_0;
          partial_next = '0;
          pads_next    = '0;
          cr_next      = 1'b0;
          error_next   = '0;
        end
        KIND_FAIL: begin
          err_sum    = sat_add(error_count, ONE_W);
          error_next = err_sum;
        end
        KIND_PAD: begin
          pads_next = sat_add(pending_pads, ONE_W);
        end
        KIND_DATA: begin
          // Pads followed by more data are all errors.
          err_sum    = sat_add(error_count, pads_w);
          error_next = err_sum;
          pads_next  = '0;
          emit       = 1'b1;
          case (phase)
            PH_0: begin
              partial_next = {head.item.digit, 2'b00};
              phase_next   = PH_1;
              emit         = 1'b0;
            end
            PH_1: begin
              dec_byte     = partial_bits | {6'b0, head.item.digit[5:4]};
              partial_next = {head.item.digit[3:0], 4'b0};
              phase_next   = PH_2;
            end
            PH_2: begin
              dec_byte     = partial_bits | {4'b0, head.item.digit[5:2]};
              partial_next = {head.item.digit[1:0], 6'b0};
              phase_next   = PH_3;
            end
            default: begin
              dec_byte   = partial_bits | {2'b0, head.item.digit};
              phase_next = PH_0;
            end
          endcase
          if (emit && text_mode) begin
            if (dec_byte == BYTE_LF) begin
              if (last_was_cr) begin
                cr_next = 1'b0;
                emit    = 1'b0;
              end else begin
                dec_byte = BYTE_CR;
              end
            end else begin
              cr_next = (dec_byte == BYTE_CR);
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign err_ext = EXTW'(err_sum);
  assign total   = (err_ext > REPORT_MAX) ? 16'hFFFF : err_ext[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode    <= 1'b0;
      phase        <= PH_0;
      partial_bits <= '0;
      pending_pads <= '0;
      last_was_cr  <= 1'b0;
      error_count  <= '0;
      dout.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        text_mode <= cfg.text_mode;
      end
      phase        <= phase_next;
      partial_bits <= partial_next;
      pending_pads <= pads_next;
      last_was_cr  <= cr_next;
      error_count  <= error_next;
      if (advance) begin
        dout.valid <= emit;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      dout.data_byte   <= fin ? 8'h00 : dec_byte;
      dout.is_final    <= fin;
      dout.error_total <= total;
    end
  end

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    advance && head.item.kind == KIND_FINISH |=>
      phase == PH_0 && pending_pads == '0 && error_count == '0 && dout.valid && dout.is_final)
    else $error("finish did not clear the decoder state");

  a_errors_grow: assert property (@(posedge clk) disable iff (rst)
    advance && head.item.kind != KIND_FINISH |=> error_count >= $past(error_count))
    else $error("error count went down without a finish");

  a_final_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.is_final |-> dout.data_byte == 8'h00)
    else $error("final result carries a nonzero data byte");

endmodule

/* rtl/base64_decoder_text_newline_core.sv */
`timescale 1ns / 1ps
// A result beat passes through the queue slot, written when its input beat is accepted, and
// then through the output register.
// Throughput: one input beat per cycle while results are taken.
// A two-entry queue separates classification from decoding, so up to two more non-whitespace
// beats still enter while a result waits in the output register.
// Reset (rst, synchronous): clears the quartet state, counters, queue and text_mode.

module base64_decoder_text_newline_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  b64d_in_if.sink    din,
  b64d_out_if.source dout,
  b64d_cfg_if.sink   cfg
);
  import b64d_pkg::*;

  // The front end turns each byte into a data digit, a pad, an invalid mark or a finish,
  // and drops whitespace outright so that it never occupies a queue slot.
  q_entry_t push;
  logic     push_ready;

  // The head of the queue feeds the back end, which owns all the decoder state.
  q_entry_t head;
  logic     pop_ready;

  b64d_front u_front (
    .din        (din),
    .push       (push),
    .push_ready (push_ready)
  );

  // The queue absorbs a stall of the output side for a beat or two before the
  // input side has to stop.
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (head),
    .pop_ready  (pop_ready)
  );

  // The back end assembles quartets, tracks pads and errors, applies the text-mode
  // newline rules and holds the result in its output register.
  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop_ready (pop_ready),
    .cfg       (cfg),
    .dout      (dout)
  );

endmodule

/* verif/tb_base64_decoder_text_newline_core.sv */
`timescale 1ns / 1ps

module tb_base64_decoder_text_newline_core;
  import b64d_pkg::*;

  localparam int COUNT_W = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int RANDOM_BEATS = 530;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  // One decoded beat as the output channel should present it.
  typedef struct {
    logic [7:0]  data;
    logic        fin;
    logic [15:0] total;
  } dec_result_t;

  // Scoreboard: keeps its own copy of the decoder state, predicts the result, if any, of every
  // accepted input beat and matches result beats against the oldest prediction.
  class decode_checker;
    bit                mode;
    phase_t            ph;
    logic [7:0]        carry;
    longint unsigned   pads;
    longint unsigned   errs;
    bit                prev_cr;
    dec_result_t       expected_q[$];
    int                errors;

    function new();
      mode   = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph      = PH_0;
      carry   = 8'h00;
      pads    = 0;
      errs    = 0;
      prev_cr = 1'b0;
    endfunction

    function longint unsigned sat(longint unsigned a, longint unsigned b);
      return (a + b > CNT_MAX) ? CNT_MAX : a + b;
    endfunction

    function void set_mode(bit m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Returns the 6-bit value of an alphabet character, or -1 for anything else.
    function int digit_of(logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return ch - "A";
      if (ch >= "a" && ch <= "z") return ch - "a" + 26;
      if (ch >= "0" && ch <= "9") return ch - "0" + 52;
      if (ch == "+") return 62;
      if (ch == "/") return 63;
      return -1;
    endfunction

    function void push(logic [7:0] d, logic f);
      dec_result_t r;
      r.data  = d;
      r.fin   = f;
      r.total = (errs > 64'hFFFF) ? 16'hFFFF : errs[15:0];
      expected_q.push_back(r);
    endfunction

    function void note_beat(logic [7:0] ch, logic fin);
      int              d;
      longint unsigned add;
      logic [7:0]      dec;
      if (fin) begin
        case (ph)
          PH_0: add = pads;
          PH_1: add = pads + 1;
          PH_2: add = (pads >= 2) ? pads - 2 : 2 - pads;
          default: add = (pads >= 1) ? pads - 1 : 1 - pads;
        endcase
        errs = sat(errs, add);
        push(8'h00, 1'b1);
        clear();
        return;
      end
      if (ch == BYTE_TAB || ch == BYTE_LF || ch == BYTE_CR || ch == BYTE_SPACE) return;
      if (ch == PAD_CHAR) begin
        pads = sat(pads, 1);
        return;
      end
      d = digit_of(ch);
      if (d < 0) begin
        errs = sat(errs, 1);
        return;
      end
      // A data digit after pads turns every waiting pad into an error.
      if (pads != 0) begin
        errs = sat(errs, pads);
        pads = 0;
      end
      case (ph)
        PH_0: begin
          carry = {d[5:0], 2'b00};
          ph    = PH_1;
          return;
        end
        PH_1: begin
          dec   = carry | {6'd0, d[5:4]};
          carry = {d[3:0], 4'd0};
          ph    = PH_2;
        end
        PH_2: begin
          dec   = carry | {4'd0, d[5:2]};
          carry = {d[1:0], 6'd0};
          ph    = PH_3;
        end
        default: begin
          dec = carry | {2'd0, d[5:0]};
          ph  = PH_0;
        end
      endcase
      if (mode) begin
        if (dec == BYTE_LF) begin
          if (prev_cr) begin
            prev_cr = 1'b0;
            return;
          end
          dec = BYTE_CR;
        end else begin
          prev_cr = (dec == BYTE_CR);
        end
      end
      push(dec, 1'b0);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_beat(logic [7:0] d, logic f, logic [15:0] t);
      dec_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat data=%02h final=%0b total=%0d with none expected",
                                  d, f, t));
        return;
      end
      r = expected_q.pop_front();
      if (d !== r.data)
        report_mismatch($sformatf("data_byte %02h, expected %02h", d, r.data));
      if (f !== r.fin)
        report_mismatch($sformatf("is_final %0b, expected %0b", f, r.fin));
      if (t !== r.total)
        report_mismatch($sformatf("error_total %0d, expected %0d", t, r.total));
    endtask

    task check_leftovers();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", expected_q.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  b64d_in_if  in_if ();
  b64d_out_if out_if ();
  b64d_cfg_if cfg_if ();

  base64_decoder_text_newline_core #(
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .din (in_if),
    .dout(out_if),
    .cfg (cfg_if)
  );

  always #10 clk = ~clk;

  decode_checker   sb;
  logic [7:0]      char_q[$];
  int              beats_sent;
  bit              tx_fast;
  bit              rx_fast;
  bit              rx_hold_req;
  longint unsigned cycle_count;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Every result beat taken by the receiver is checked against the oldest prediction.
  // Sampling at the clock edge sees the values from before the edge, so there is no race
  // with the block's own registers.
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      sb.check_beat(out_if.data_byte, out_if.is_final, out_if.error_total);
  end

  // Receiver. Before each beat it draws a random stall, except in fast stretches, which
  // toggle at random. When the stimulus asks for it, the receiver holds ready low for a
  // long stretch so that the block backs up into its input.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // Offers one input beat after a random gap and returns at the edge where it is taken.
  // Valid is left high so that a following beat with no gap goes out back to back.
  task automatic send_beat(logic [7:0] b, logic fin);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.finish  <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_beat(b, fin);
    beats_sent++;
  endtask

  // The sender stops until the receiver has taken every predicted result.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // A beat that produces no result may still be inside the block when the last
  // result has come out, so the task waits out SETTLE_CYCLES before the register changes.
  task automatic write_mode(bit m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.text_mode <= m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [7:0] digit_char(logic [5:0] d);
    if (d < 26) return "A" + d;
    if (d < 52) return "a" + (d - 26);
    if (d < 62) return "0" + (d - 52);
    return (d == 62) ? "+" : "/";
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return BYTE_TAB;
      1: return BYTE_LF;
      2: return BYTE_CR;
      default: return BYTE_SPACE;
    endcase
  endfunction

  // Queues one character, now and then preceded by whitespace that the decoder skips.
  task automatic put_char(logic [7:0] c);
    if ($urandom_range(0, 7) == 0) char_q.push_back(blank_char());
    char_q.push_back(c);
  endtask

  // Encodes n random bytes, heavy in CR and LF so that text mode has work to do.
  // A few messages lose their pads or gain one too many.
  task automatic build_clean(int n);
    logic [7:0] raw[$];
    logic [7:0] b0, b1, b2;
    int         i, left, r;
    bit         drop_pads;
    drop_pads = ($urandom_range(0, 9) == 0);
    char_q.delete();
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 3);
      raw.push_back(r == 0 ? BYTE_CR : r == 1 ? BYTE_LF : 8'($urandom_range(0, 255)));
    end
    for (i = 0; i < n; i += 3) begin
      left = n - i;
      b0 = raw[i];
      b1 = (left > 1) ? raw[i + 1] : 8'h00;
      b2 = (left > 2) ? raw[i + 2] : 8'h00;
      put_char(digit_char(b0[7:2]));
      put_char(digit_char({b0[1:0], b1[7:4]}));
      if (left > 1) put_char(digit_char({b1[3:0], b2[7:6]}));
      else if (!drop_pads) put_char(PAD_CHAR);
      if (left > 2) put_char(digit_char(b2[5:0]));
      else if (!drop_pads) put_char(PAD_CHAR);
    end
    if ($urandom_range(0, 19) == 0) put_char(PAD_CHAR);
  endtask

  // Random junk: digits, pads, whitespace and arbitrary bytes in any order.
  task automatic build_noise();
    int n, i, r;
    char_q.delete();
    n = $urandom_range(1, 16);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) char_q.push_back(digit_char(6'($urandom_range(0, 63))));
      else if (r < 55) char_q.push_back(PAD_CHAR);
      else if (r < 70) char_q.push_back(blank_char());
      else char_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Sends the queued characters and a finish beat, which carries a random ignored byte.
  // Now and then the sender waits mid-message until all results are out.
  task automatic send_message();
    foreach (char_q[i]) begin
      if ($urandom_range(0, 59) == 0) drain_results();
      send_beat(char_q[i], 1'b0);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int i;
    sb = new();
    cycle_count = 0;
    beats_sent  = 0;
    tx_fast     = 1'b0;
    rx_fast     = 1'b0;
    rx_hold_req = 1'b0;
    rst              <= 1'b1;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= 8'h00;
    in_if.finish     <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.text_mode <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, binary mode: a plain quartet, each whitespace character, the all-ones
    // digits, the lowest and highest invalid bytes, a pad followed by a digit, and a
    // finish in the middle of a quartet.
    write_mode(1'b0);
    char_q = '{"T", "W", "F", "u", BYTE_TAB, BYTE_LF, BYTE_CR, BYTE_SPACE,
               "/", "/", "/", "/", 8'h00, 8'hFF, "A", PAD_CHAR, "B"};
    send_message();

    // Text mode: the bytes CR LF LF decode to one CR, a dropped LF and a lone LF that
    // turns into CR; then a finish right after the first digit of a quartet.
    write_mode(1'b1);
    char_q = '{"D", "Q", "o", "K", "Q"};
    send_message();

    // The receiver stalls for a long stretch while the sender pushes a long message back
    // to back, so the queue fills and input ready has to drop.
    write_mode(1'b0);
    rx_hold_req = 1'b1;
    tx_fast     = 1'b1;
    build_clean(60);
    send_message();
    tx_fast = 1'b0;

    // Random part: mostly well-formed messages with random content, the rest noise, with
    // the text mode register changed between messages from time to time.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if ($urandom_range(0, 5) == 0) write_mode(1'($urandom_range(0, 1)));
      tx_fast = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) build_clean($urandom_range(0, 12));
      else build_noise();
      send_message();
    end
    tx_fast = 1'b0;

    // Wait for the remaining results, with a bound, then give the block time to show any
    // stray beat before the verdict.
    in_if.valid <= 1'b0;
    i = 0;
    while (sb.pending() != 0 && i < 5000) begin
      @(posedge clk);
      i++;
    end
    repeat (10) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/b64d_pkg.sv
rtl/b64d_ifs.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_text_newline_core.sv
verif/tb_base64_decoder_text_newline_core.sv
